>>> src/ifor_pkg.sv
// ----------------------------------------------------------------------------
// ifor_pkg
// Shared types for the first-occurrence index renumbering unit: controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ifor_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned COUNT_W = 6;

  // Result kinds.
  localparam logic KIND_ID   = 1'b0;
  localparam logic KIND_DUMP = 1'b1;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } ifor_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic lookup;     // look up the accepted input beat and load its result
    logic dump_step;  // emit the next stored entry and shift the row down
  } ifor_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic out_free;   // output register can take a new beat this cycle
    logic dump_last;  // the next dump step emits the final stored entry
  } ifor_sts_t;

endpackage

>>> src/ifor_ctrl.sv
// ----------------------------------------------------------------------------
// ifor_ctrl
// Controller: accepts input beats while idle and sequences the dump of the
// distinct index row after the last beat of a list.
// ----------------------------------------------------------------------------
module ifor_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_list_end,
  output logic              in_stall,
  output ifor_pkg::ifor_cmd_t cmd,
  input  ifor_pkg::ifor_sts_t sts
);
  import ifor_pkg::*;

  ifor_state_t state_r;
  ifor_state_t state_nxt;

  // Output decode.
  always_comb begin
    cmd.lookup    = (state_r == ST_IDLE) && in_valid && sts.out_free;
    cmd.dump_step = (state_r == ST_DUMP) && sts.out_free;
    in_stall      = (state_r != ST_IDLE) || !sts.out_free;
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.lookup && in_list_end) begin
          state_nxt = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (cmd.dump_step && sts.dump_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/ifor_dpath.sv
// ----------------------------------------------------------------------------
// ifor_dpath
// Datapath: a row of index cells compared in parallel with the incoming key,
// the entry count and overflow flag, and the output register.
// ----------------------------------------------------------------------------
module ifor_dpath #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ifor_pkg::VALUE_W-1:0]  in_vertex_index,
  input  logic                          in_list_end,
  input  ifor_pkg::ifor_cmd_t           cmd,
  output ifor_pkg::ifor_sts_t           sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_result_kind,
  output logic [ifor_pkg::VALUE_W-1:0]  out_result_value,
  output logic [ifor_pkg::COUNT_W-1:0]  out_distinct_count,
  output logic                          out_table_overflow,
  output logic                          out_run_last
);
  import ifor_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EXT_W = INDEX_WIDTH + VALUE_W;

  // Index cells and bookkeeping.
  logic [INDEX_WIDTH-1:0] cell_r [TABLE_DEPTH];
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   ovf_seen_r, ovf_seen_nxt;
  logic [CNT_W-1:0]       dump_left_r, dump_left_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic               kind_r, kind_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [CNT_W-1:0]   ocount_r, ocount_nxt;
  logic               oovf_r, oovf_nxt;
  logic               olast_r, olast_nxt;

  logic [EXT_W-1:0]       key_ext;
  logic [INDEX_WIDTH-1:0] key;
  logic [EXT_W-1:0]       head_ext;
  logic                   found;
  logic [IDX_W-1:0]       match_id;
  logic                   full;
  logic                   append;

  // Key is the low INDEX_WIDTH bits of the input index.
  assign key_ext  = EXT_W'(in_vertex_index);
  assign key      = key_ext[INDEX_WIDTH-1:0];
  assign head_ext = EXT_W'(cell_r[0]);
  assign full     = (count_r == CNT_W'(TABLE_DEPTH));

  // Parallel compare against the occupied cells; entries are distinct, so at
  // most one cell matches and its position is gathered by OR.
  always_comb begin
    found    = 1'b0;
    match_id = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if ((CNT_W'(i) < count_r) && (cell_r[i] == key)) begin
        found    = 1'b1;
        match_id = match_id | IDX_W'(i);
      end
    end
  end

  assign append = cmd.lookup && !found && !full;

  // Next values of count, overflow flag, dump counter and output register.
  always_comb begin
    count_nxt     = count_r;
    ovf_seen_nxt  = ovf_seen_r;
    dump_left_nxt = dump_left_r;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    ocount_nxt    = ocount_r;
    oovf_nxt      = oovf_r;
    olast_nxt     = olast_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.lookup) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_ID;
      olast_nxt     = !in_list_end;
      oovf_nxt      = 1'b0;
      if (found) begin
        value_nxt = VALUE_W'(match_id);
      end else if (!full) begin
        value_nxt = VALUE_W'(count_r);
        count_nxt = count_r + CNT_W'(1);
      end else begin
        value_nxt    = '0;
        oovf_nxt     = 1'b1;
        ovf_seen_nxt = 1'b1;
      end
      ocount_nxt    = count_nxt;
      dump_left_nxt = count_nxt;
    end else if (cmd.dump_step) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_DUMP;
      value_nxt     = head_ext[VALUE_W-1:0];
      ocount_nxt    = count_r;
      oovf_nxt      = ovf_seen_r;
      olast_nxt     = sts.dump_last;
      dump_left_nxt = dump_left_r - CNT_W'(1);
      if (sts.dump_last) begin
        count_nxt    = '0;
        ovf_seen_nxt = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_seen_r  <= 1'b0;
      dump_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_seen_r  <= ovf_seen_nxt;
      dump_left_r <= dump_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload registers.
  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    value_r  <= value_nxt;
    ocount_r <= ocount_nxt;
    oovf_r   <= oovf_nxt;
    olast_r  <= olast_nxt;
  end

  // Cell row: append at the count position, shift toward cell 0 on dump.
  // The top cell has no neighbor above it and only ever takes an append.
  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
      if (cmd.dump_step) begin
        cell_r[i] <= cell_r[i+1];
      end else if (append && (count_r == CNT_W'(i))) begin
        cell_r[i] <= key;
      end
    end
    if (!cmd.dump_step && append && (count_r == CNT_W'(TABLE_DEPTH - 1))) begin
      cell_r[TABLE_DEPTH-1] <= key;
    end
  end

  // Status and ports.
  assign sts.out_free        = !out_valid_r || !out_stall;
  assign sts.dump_last       = (dump_left_r == CNT_W'(1));
  assign out_valid           = out_valid_r;
  assign out_result_kind     = kind_r;
  assign out_result_value    = value_r;
  assign out_distinct_count  = COUNT_W'(ocount_r);
  assign out_table_overflow  = oovf_r;
  assign out_run_last        = olast_r;

endmodule

>>> src/index_first_occurrence_renumber_unit.sv
// ----------------------------------------------------------------------------
// index_first_occurrence_renumber_unit
// Renumbers vertex indices by order of first appearance within a list and
// dumps the distinct indices in that order after the last index of a list.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Fields
//  --------+-----------+--------------------+----------------------------------
//  in_     | input     | in_valid/in_stall  | vertex_index, list_end
//  out_    | output    | out_valid/out_stall| result_kind, result_value,
//          |           |                    | distinct_count, table_overflow,
//          |           |                    | run_last
//
// An index beat that does not end a list is a single lookup: all occupied
// cells are compared in parallel, so one beat is accepted per cycle unless
// the output stalls. A beat that ends a list is followed by one dump beat per
// stored entry; the dump shifts the row toward cell 0 and stalls the input.
// Reset clears the count, the overflow flag, the controller and the output
// valid; the cell contents are not cleared and need no clearing pass.
// The output register takes a new beat in the cycle the held one is taken, and
// a stalled output holds the input stalled and the dump paused.
// ----------------------------------------------------------------------------
module index_first_occurrence_renumber_unit #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ifor_pkg::VALUE_W-1:0] in_vertex_index,
  input  logic                         in_list_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_result_kind,
  output logic [ifor_pkg::VALUE_W-1:0] out_result_value,
  output logic [ifor_pkg::COUNT_W-1:0] out_distinct_count,
  output logic                         out_table_overflow,
  output logic                         out_run_last
);
  import ifor_pkg::*;

  ifor_cmd_t cmd;
  ifor_sts_t sts;

  // Sequencing of lookups and dumps.
  ifor_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_list_end (in_list_end),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

  // Cell row, bookkeeping and output register.
  ifor_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_vertex_index    (in_vertex_index),
    .in_list_end        (in_list_end),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_result_value   (out_result_value),
    .out_distinct_count (out_distinct_count),
    .out_table_overflow (out_table_overflow),
    .out_run_last       (out_run_last)
  );

endmodule

>>> test/tb_index_first_occurrence_renumber_unit.sv
// ----------------------------------------------------------------------------
// tb_index_first_occurrence_renumber_unit
// Self-checking bench for the index renumbering unit. A directed table covers
// the index extremes, repeated indices, a full table with overflow, and list
// ends with and without overflow. Random lists follow: mostly short lists
// drawn from small pools of near-equal indices, some lists long enough to
// overflow the table, and some noise. Every accepted beat runs through a
// local renumbering model, and each output beat is checked against the oldest
// expected beat. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_index_first_occurrence_renumber_unit;
  import ifor_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam int INDEX_WIDTH = 16;
  localparam int HALF_PERIOD = 2;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 340;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT = 400000;

  // One output beat as the bench expects it.
  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic               ovf;
    logic               last;
  } result_beat_t;

  // One row of the directed table: reps indices base, base+step, ...; the
  // list end flag and the typed-in id result apply to the final index only.
  typedef struct packed {
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] step;
    logic [COUNT_W-1:0] reps;
    logic               list_end;
    logic               typed;
    logic [VALUE_W-1:0] id;
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } dir_row_t;

  localparam int DIR_ROWS = 16;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{16'hFFFF, 16'd0, 6'd1,  1'b0, 1'b1, 16'd0,  6'd1,  1'b0},
    '{16'h0000, 16'd0, 6'd1,  1'b0, 1'b1, 16'd1,  6'd2,  1'b0},
    '{16'hFFFF, 16'd0, 6'd1,  1'b0, 1'b1, 16'd0,  6'd2,  1'b0},
    '{16'h0000, 16'd0, 6'd1,  1'b1, 1'b1, 16'd1,  6'd2,  1'b0},
    '{16'h1234, 16'd0, 6'd1,  1'b1, 1'b1, 16'd0,  6'd1,  1'b0},
    '{16'h5555, 16'd0, 6'd1,  1'b0, 1'b0, 16'd0,  6'd0,  1'b0},
    '{16'hAAAA, 16'd0, 6'd1,  1'b0, 1'b0, 16'd0,  6'd0,  1'b0},
    '{16'h5555, 16'd0, 6'd1,  1'b1, 1'b1, 16'd0,  6'd2,  1'b0},
    '{16'h0100, 16'd1, 6'd32, 1'b0, 1'b1, 16'd31, 6'd32, 1'b0},
    '{16'h8000, 16'd0, 6'd1,  1'b0, 1'b1, 16'd0,  6'd32, 1'b1},
    '{16'h0100, 16'd0, 6'd1,  1'b0, 1'b1, 16'd0,  6'd32, 1'b0},
    '{16'h011F, 16'd0, 6'd1,  1'b1, 1'b1, 16'd31, 6'd32, 1'b0},
    '{16'hFF00, 16'd1, 6'd32, 1'b0, 1'b1, 16'd31, 6'd32, 1'b0},
    '{16'h0001, 16'd0, 6'd1,  1'b1, 1'b1, 16'd0,  6'd32, 1'b1},
    '{16'h7FFF, 16'd0, 6'd1,  1'b0, 1'b1, 16'd0,  6'd1,  1'b0},
    '{16'h7FFF, 16'd0, 6'd1,  1'b1, 1'b1, 16'd0,  6'd1,  1'b0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] in_vertex_index = '0;
  logic               in_list_end = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_result_kind;
  logic [VALUE_W-1:0] out_result_value;
  logic [COUNT_W-1:0] out_distinct_count;
  logic               out_table_overflow;
  logic               out_run_last;

  // Model state of the distinct index table.
  logic [INDEX_WIDTH-1:0] seen_index [TABLE_DEPTH];
  int                     seen_count = 0;
  logic                   seen_ovf = 1'b0;

  result_beat_t pending_results [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           random_sent = 0;
  bit           no_idle = 1'b0;
  int           hold_asked = 0;
  int           hold_served = 0;

  index_first_occurrence_renumber_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_vertex_index   (in_vertex_index),
    .in_list_end       (in_list_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_result_value  (out_result_value),
    .out_distinct_count(out_distinct_count),
    .out_table_overflow(out_table_overflow),
    .out_run_last      (out_run_last)
  );

  // Free-running clock.
  always begin
    #HALF_PERIOD clk = ~clk;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Renumber one accepted index and queue the beats it must produce.
  // Returns the number of beats queued.
  function automatic int renumber_index(input logic [VALUE_W-1:0] vertex,
                                        input logic list_end);
    logic [INDEX_WIDTH-1:0] key;
    int                     id;
    bit                     hit;
    logic                   ovf;
    int                     produced;
    key = vertex[INDEX_WIDTH-1:0];
    id = 0;
    hit = 1'b0;
    ovf = 1'b0;
    for (int k = 0; k < seen_count; k++) begin
      if (!hit && seen_index[k] == key) begin
        id = k;
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (seen_count < TABLE_DEPTH) begin
        id = seen_count;
        seen_index[seen_count] = key;
        seen_count++;
      end else begin
        ovf = 1'b1;
        seen_ovf = 1'b1;
      end
    end
    pending_results.push_back('{KIND_ID, VALUE_W'(id), COUNT_W'(seen_count), ovf,
                                !list_end});
    produced = 1;
    // A list end dumps the table in order of first appearance.
    if (list_end) begin
      for (int k = 0; k < seen_count; k++) begin
        pending_results.push_back('{KIND_DUMP, VALUE_W'(seen_index[k]),
                                    COUNT_W'(seen_count), seen_ovf,
                                    k == seen_count - 1});
        produced++;
      end
      seen_count = 0;
      seen_ovf = 1'b0;
    end
    return produced;
  endfunction

  // Offer one beat, idling at random first; returns once it is taken.
  task automatic send_index(input logic [VALUE_W-1:0] vertex, input logic list_end,
                            output int produced);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vertex_index <= vertex;
    in_list_end <= list_end;
    do @(posedge clk); while (in_stall);
    produced = renumber_index(vertex, list_end);
  endtask

  // One random list: short lists from small pools of near-equal indices,
  // long lists that overflow the table, or noise with early list ends.
  task automatic send_random_list();
    logic [VALUE_W-1:0] pool [12];
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] vertex;
    logic               list_end;
    int                 mode;
    int                 len;
    int                 pool_n;
    int                 produced;
    mode = $urandom_range(99);
    base = VALUE_W'($urandom);
    pool_n = $urandom_range(1, 12);
    for (int j = 0; j < 12; j++) begin
      pool[j] = ($urandom_range(2) == 0) ? base ^ (VALUE_W'(1) << $urandom_range(15))
                                         : VALUE_W'($urandom);
    end
    if (mode < 12) len = $urandom_range(33, 48);
    else if (mode < 22) len = $urandom_range(1, 8);
    else len = $urandom_range(1, 20);
    for (int k = 0; k < len; k++) begin
      if (random_sent == 100) hold_asked++;
      no_idle = (random_sent >= 200 && random_sent < 260);
      if (random_sent == 320) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      list_end = (k == len - 1);
      if (mode < 12) begin
        vertex = ($urandom_range(4) == 0) ? base + VALUE_W'($urandom_range(k))
                                          : base + VALUE_W'(k);
      end else if (mode < 22) begin
        vertex = VALUE_W'($urandom);
        list_end = list_end || ($urandom_range(5) == 0);
      end else begin
        vertex = pool[$urandom_range(pool_n - 1)];
      end
      send_index(vertex, list_end, produced);
      random_sent++;
    end
  endtask

  // Stimulus: reset, directed table, random lists, then drain and report.
  initial begin
    result_beat_t typed_beat;
    logic [VALUE_W-1:0] vertex;
    logic list_end;
    int produced;
    int leftover;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      for (int k = 0; k < DIRECTED[r].reps; k++) begin
        vertex = DIRECTED[r].base + VALUE_W'(k) * DIRECTED[r].step;
        list_end = DIRECTED[r].list_end && (k == DIRECTED[r].reps - 1);
        send_index(vertex, list_end, produced);
        // Where the row gives the id result by hand, check against that.
        if (DIRECTED[r].typed && k == DIRECTED[r].reps - 1) begin
          typed_beat = '{KIND_ID, DIRECTED[r].id, DIRECTED[r].count, DIRECTED[r].ovf,
                         !list_end};
          pending_results[pending_results.size() - produced] = typed_beat;
        end
      end
    end

    while (random_sent < RANDOM_ITEMS) send_random_list();
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    leftover = pending_results.size();
    if (leftover != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, leftover);
    end
    if (mismatch_count == 0 && leftover == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side: random stalls, a quiet stretch, and one long hold-off.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        out_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_served++;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 35);
      end
    end
  end

  // Compare each taken result beat with the oldest expected one.
  always @(posedge clk) begin
    result_beat_t got;
    result_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_result_kind, out_result_value, out_distinct_count,
              out_table_overflow, out_run_last};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat kind=%0d value=%h count=%0d ovf=%0d last=%0d",
                 $time, got.kind, got.value, got.count, got.ovf, got.last);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: expected kind=%0d value=%h count=%0d ovf=%0d last=%0d",
                   $time, want.kind, want.value, want.count, want.ovf, want.last);
          $display("%0t: actual   kind=%0d value=%h count=%0d ovf=%0d last=%0d",
                   $time, got.kind, got.value, got.count, got.ovf, got.last);
          mismatch_count++;
        end
      end
    end
  end

endmodule
